@@ design/bmf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the battery monitor filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int SAMPLE_BITS        = 12;
  localparam int BATT_FILTER_LEN    = 768;
  localparam int CURRENT_FILTER_LEN = 32;
  localparam int TEMP_FILTER_LEN    = 256;

  // battery path carries sample plus offset, one bit wider than a sample
  localparam int BATT_W = SAMPLE_BITS + 1;

  localparam int MAX_LEN_BC = (BATT_FILTER_LEN > CURRENT_FILTER_LEN) ?
                              BATT_FILTER_LEN : CURRENT_FILTER_LEN;
  localparam int MAX_LEN    = (MAX_LEN_BC > TEMP_FILTER_LEN) ? MAX_LEN_BC : TEMP_FILTER_LEN;

  // integral stays below L * 2^BATT_W
  localparam int ACC_W = BATT_W + $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [BATT_W-1:0] PCT00_TH  = BATT_W'(1646);
  localparam logic [BATT_W-1:0] PCT10_TH  = BATT_W'(1698);
  localparam logic [BATT_W-1:0] PCT30_TH  = BATT_W'(1780);
  localparam logic [BATT_W-1:0] PCT50_TH  = BATT_W'(1936);
  localparam logic [BATT_W-1:0] PCT100_TH = BATT_W'(2130);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATT_OFFSET = 3'd0,
    CFG_TEMP_GAIN   = 3'd1,
    CFG_TEMP_OFFSET = 3'd2,
    CFG_CHARGE_LOW  = 3'd3,
    CFG_CHARGE_HIGH = 3'd4,
    CFG_HOLD_COUNT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LANE_BATT = 2'd0,
    LANE_CURR = 2'd1,
    LANE_TEMP = 2'd2
  } lane_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] battery_sample;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic [SAMPLE_BITS-1:0] temp_sample;
  } in_item_t;

  typedef struct packed {
    logic [BATT_W-1:0]      battery_filtered;
    logic [SAMPLE_BITS-1:0] current_filtered;
    logic [SAMPLE_BITS-1:0] temp_filtered;
    logic signed [15:0]     temperature_x100;
    logic                   charge_ok;
    logic [6:0]             battery_percent;
    logic [1:0]             battery_level;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] battery_offset;
    logic signed [15:0]     temp_gain;
    logic signed [15:0]     temp_offset;
    logic [SAMPLE_BITS-1:0] charge_low;
    logic [SAMPLE_BITS-1:0] charge_high;
    logic [7:0]             hold_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    battery_offset: SAMPLE_BITS'(0),
    temp_gain:      16'sd4096,
    temp_offset:    16'sd0,
    charge_low:     SAMPLE_BITS'(1900),
    charge_high:    SAMPLE_BITS'(3016),
    hold_count:     8'd128
  };

  // lane pipeline strobes: sample load, reciprocal multiply, integral update,
  // rounding multiply
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic fin;
  } lane_ctl_t;

  // merge strobes: capture of lane results, output register load
  typedef struct packed {
    logic cap;
    logic out;
  } merge_ctl_t;

endpackage

@@ design/bmf_in_if.sv @@
// ----------------------------------------------------------------------------
// bmf_in_if
// Scan request channel: valid/ready with one three-channel ADC scan.
// ----------------------------------------------------------------------------
interface bmf_in_if;
  import bmf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bmf_out_if.sv @@
// ----------------------------------------------------------------------------
// bmf_out_if
// Result channel: valid/ready with filtered values and battery status.
// ----------------------------------------------------------------------------
interface bmf_out_if;
  import bmf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bmf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bmf_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface bmf_cfg_if;
  import bmf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/bmf_lane.sv @@
// ----------------------------------------------------------------------------
// bmf_lane
// One leaky-integrator filter lane with priming and ceil rounding.
// ----------------------------------------------------------------------------
module bmf_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bmf_pkg::lane_e            lane_i,
  input  bmf_pkg::lane_ctl_t        ctl_i,
  input  logic [bmf_pkg::BATT_W-1:0] smp_i,
  output logic [bmf_pkg::BATT_W-1:0] filt_o
);
  import bmf_pkg::*;

  localparam int PROD_W = 2 * ACC_W + 1;
  localparam int SH_W   = $clog2(PROD_W);

  // floor(x / L) = (x * RC) >> SH, exact for any ACC_W-bit x
  localparam int B_SH = ACC_W + $clog2(BATT_FILTER_LEN);
  localparam int C_SH = ACC_W + $clog2(CURRENT_FILTER_LEN);
  localparam int T_SH = ACC_W + $clog2(TEMP_FILTER_LEN);
  localparam longint B_RC = ((64'd1 << B_SH) + BATT_FILTER_LEN - 1) / BATT_FILTER_LEN;
  localparam longint C_RC = ((64'd1 << C_SH) + CURRENT_FILTER_LEN - 1) / CURRENT_FILTER_LEN;
  localparam longint T_RC = ((64'd1 << T_SH) + TEMP_FILTER_LEN - 1) / TEMP_FILTER_LEN;

  localparam logic [ACC_W-1:0] SMP_MAX = ACC_W'({BATT_W{1'b1}});

  logic [CNT_W-1:0]  len;
  logic [ACC_W:0]    rc;
  logic [SH_W-1:0]   sh;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              priming;

  logic [BATT_W-1:0] smp1_q, smp2_q, smp3_q, smp4_q;
  logic [PROD_W-1:0] prod2_q, prod4_q;
  logic              prime3_q, prime4_q;
  logic [ACC_W-1:0]  quo2;
  logic [ACC_W-1:0]  acc_rnd;

  always_comb begin
    unique case (lane_i)
      LANE_BATT: begin
        len = CNT_W'(BATT_FILTER_LEN);
        rc  = (ACC_W + 1)'(B_RC);
        sh  = SH_W'(B_SH);
      end
      LANE_CURR: begin
        len = CNT_W'(CURRENT_FILTER_LEN);
        rc  = (ACC_W + 1)'(C_RC);
        sh  = SH_W'(C_SH);
      end
      default: begin
        len = CNT_W'(TEMP_FILTER_LEN);
        rc  = (ACC_W + 1)'(T_RC);
        sh  = SH_W'(T_SH);
      end
    endcase
  end

  assign priming = (cnt_q < len);
  assign quo2    = ACC_W'(prod2_q >> sh);
  assign acc_rnd = acc_q + (ACC_W'(len) - ACC_W'(1));

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (ctl_i.upd) begin
      if (priming) begin
        acc_d = acc_q + ACC_W'(smp2_q);
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        acc_d = acc_q - quo2 + ACC_W'(smp2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // prime4_q marks a result that passes the raw sample
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      smp1_q <= smp_i;
    end
    if (ctl_i.mul) begin
      prod2_q <= PROD_W'(acc_q) * PROD_W'(rc);
      smp2_q  <= smp1_q;
    end
    if (ctl_i.upd) begin
      prime3_q <= priming;
      smp3_q   <= smp2_q;
    end
    if (ctl_i.fin) begin
      prime4_q <= prime3_q;
      smp4_q   <= smp3_q;
      prod4_q  <= PROD_W'(acc_rnd) * PROD_W'(rc);
    end
  end

  assign filt_o = prime4_q ? smp4_q : BATT_W'(prod4_q >> sh);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len)
    else $error("priming count ran past filter length");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACC_W'(len) * SMP_MAX)
    else $error("integral exceeds L times largest sample");

  a_prime_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.upd && priming |=> cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
    else $error("priming count did not advance on update");

endmodule

@@ design/bmf_merge.sv @@
// ----------------------------------------------------------------------------
// bmf_merge
// Combines lane results: temperature scaling, charge window, battery
// percentage, low-battery level with hold hysteresis, output register.
// ----------------------------------------------------------------------------
module bmf_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmf_pkg::merge_ctl_t        ctl_i,
  input  bmf_pkg::cfg_t              cfg_i,
  input  logic [bmf_pkg::BATT_W-1:0] batt_filt_i,
  input  logic [bmf_pkg::BATT_W-1:0] curr_filt_i,
  input  logic [bmf_pkg::BATT_W-1:0] temp_filt_i,
  output bmf_pkg::out_item_t         item_o
);
  import bmf_pkg::*;

  typedef enum logic [2:0] {
    SEG_ZERO,
    SEG_P00,
    SEG_P10,
    SEG_P30,
    SEG_P50,
    SEG_FULL
  } seg_e;

  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_LOW    = 2'd1,
    LVL_VLOW   = 2'd2
  } lvl_e;

  localparam int PCT_NW = 14;
  localparam int PROD_W = 2 * PCT_NW + 1;
  localparam int SH_W   = $clog2(PROD_W);

  localparam int D1 = int'(PCT10_TH) - int'(PCT00_TH);
  localparam int D2 = int'(PCT30_TH) - int'(PCT10_TH);
  localparam int D3 = int'(PCT50_TH) - int'(PCT30_TH);
  localparam int D4 = int'(PCT100_TH) - int'(PCT50_TH);
  localparam int SH1 = PCT_NW + $clog2(D1);
  localparam int SH2 = PCT_NW + $clog2(D2);
  localparam int SH3 = PCT_NW + $clog2(D3);
  localparam int SH4 = PCT_NW + $clog2(D4);
  localparam longint RC1 = ((64'd1 << SH1) + D1 - 1) / D1;
  localparam longint RC2 = ((64'd1 << SH2) + D2 - 1) / D2;
  localparam longint RC3 = ((64'd1 << SH3) + D3 - 1) / D3;
  localparam longint RC4 = ((64'd1 << SH4) + D4 - 1) / D4;

  // capture stage
  logic [BATT_W-1:0]      bf, bf_q;
  logic [SAMPLE_BITS-1:0] cf, tf, cf_q, tf_q;
  logic [15:0]            gain_mag;
  logic                   neg_q;
  logic [27:0]            tprod_q;
  logic                   chg_ok_q;
  seg_e                   seg_d, seg_q;
  logic [PCT_NW-1:0]      num_d, num_q;

  // output stage
  logic [PCT_NW:0]        rc;
  logic [SH_W-1:0]        sh;
  logic [6:0]             base;
  logic [6:0]             pct;
  logic [15:0]            tmag, tq;
  logic                   lo30, lo10;
  lvl_e                   level_q;
  logic [7:0]             timer_q;
  logic [8:0]             tick;
  logic                   tick_done;

  assign bf = batt_filt_i;
  assign cf = curr_filt_i[SAMPLE_BITS-1:0];
  assign tf = temp_filt_i[SAMPLE_BITS-1:0];
  assign gain_mag = cfg_i.temp_gain[15] ? (~cfg_i.temp_gain + 16'd1) : cfg_i.temp_gain;

  always_comb begin
    seg_d = SEG_FULL;
    num_d = '0;
    if (bf < PCT00_TH) begin
      seg_d = SEG_ZERO;
    end else if (bf < PCT10_TH) begin
      seg_d = SEG_P00;
      num_d = PCT_NW'(bf - PCT00_TH) * PCT_NW'(10);
    end else if (bf < PCT30_TH) begin
      seg_d = SEG_P10;
      num_d = PCT_NW'(bf - PCT10_TH) * PCT_NW'(20);
    end else if (bf < PCT50_TH) begin
      seg_d = SEG_P30;
      num_d = PCT_NW'(bf - PCT30_TH) * PCT_NW'(20);
    end else if (bf < PCT100_TH) begin
      seg_d = SEG_P50;
      num_d = PCT_NW'(bf - PCT50_TH) * PCT_NW'(50);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      bf_q     <= bf;
      cf_q     <= cf;
      tf_q     <= tf;
      neg_q    <= cfg_i.temp_gain[15];
      tprod_q  <= 28'(tf) * 28'(gain_mag);
      chg_ok_q <= (cf >= cfg_i.charge_low) && (cf <= cfg_i.charge_high);
      seg_q    <= seg_d;
      num_q    <= num_d;
    end
  end

  always_comb begin
    unique case (seg_q)
      SEG_ZERO: begin base = 7'd0;   rc = '0;            sh = '0;        end
      SEG_P00:  begin base = 7'd0;   rc = (PCT_NW+1)'(RC1); sh = SH_W'(SH1); end
      SEG_P10:  begin base = 7'd10;  rc = (PCT_NW+1)'(RC2); sh = SH_W'(SH2); end
      SEG_P30:  begin base = 7'd30;  rc = (PCT_NW+1)'(RC3); sh = SH_W'(SH3); end
      SEG_P50:  begin base = 7'd50;  rc = (PCT_NW+1)'(RC4); sh = SH_W'(SH4); end
      default:  begin base = 7'd100; rc = '0;            sh = '0;        end
    endcase
  end

  assign pct = base + 7'((PROD_W'(num_q) * PROD_W'(rc)) >> sh);

  // truncate toward zero: scale the magnitude, then restore the sign
  assign tmag = tprod_q[27:12];
  assign tq   = (neg_q ? (16'd0 - tmag) : tmag) + cfg_i.temp_offset;

  assign lo30      = bf_q < PCT30_TH;
  assign lo10      = bf_q < PCT10_TH;
  assign tick      = {1'b0, timer_q} + 9'd1;
  assign tick_done = tick >= {1'b0, cfg_i.hold_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_NORMAL;
      timer_q <= '0;
      item_o  <= '0;
    end else if (ctl_i.out) begin
      item_o.battery_filtered <= bf_q;
      item_o.current_filtered <= cf_q;
      item_o.temp_filtered    <= tf_q;
      item_o.temperature_x100 <= tq;
      item_o.charge_ok        <= chg_ok_q;
      item_o.battery_percent  <= pct;
      unique case (level_q)
        LVL_NORMAL: begin
          if (lo30) begin
            timer_q <= tick_done ? 8'd0 : tick[7:0];
            if (tick_done) begin
              level_q <= LVL_LOW;
              item_o.battery_level <= LVL_LOW;
            end else begin
              item_o.battery_level <= LVL_NORMAL;
            end
          end else begin
            timer_q <= '0;
            item_o.battery_level <= LVL_NORMAL;
          end
        end
        LVL_LOW: begin
          if (!lo30 || lo10) begin
            timer_q <= tick_done ? 8'd0 : tick[7:0];
            if (tick_done) begin
              level_q <= lo10 ? LVL_VLOW : LVL_NORMAL;
              item_o.battery_level <= lo10 ? LVL_VLOW : LVL_NORMAL;
            end else begin
              item_o.battery_level <= LVL_LOW;
            end
          end else begin
            timer_q <= '0;
            item_o.battery_level <= LVL_LOW;
          end
        end
        LVL_VLOW: begin
          if (!lo10) begin
            timer_q <= tick_done ? 8'd0 : tick[7:0];
            if (tick_done) begin
              level_q <= LVL_LOW;
              item_o.battery_level <= LVL_LOW;
            end else begin
              item_o.battery_level <= LVL_VLOW;
            end
          end else begin
            timer_q <= '0;
            item_o.battery_level <= LVL_VLOW;
          end
        end
        default: begin
          level_q <= LVL_NORMAL;
          timer_q <= '0;
          item_o.battery_level <= LVL_NORMAL;
        end
      endcase
    end
  end

  a_lvl_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> $past(ctl_i.out))
    else $error("battery level changed without an output load");

  a_lvl_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |->
      (level_q == lvl_e'($past(level_q) + 2'd1)) || ($past(level_q) == lvl_e'(level_q + 2'd1)))
    else $error("battery level skipped a step");

  a_lvl_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> timer_q == 8'd0)
    else $error("hold timer not cleared on level change");

endmodule

@@ design/battery_monitor_filter_unit.sv @@
// ----------------------------------------------------------------------------
// battery_monitor_filter_unit
// Battery monitor ADC filter: three leaky-integrator lanes and a merge stage.
// ----------------------------------------------------------------------------
// Each request is one scan of battery, charge-current and temperature
// conversions; each scan yields exactly one result, in order. The three
// channels are filtered in parallel lanes, each lane a leaky integrator of
// its own length with a priming phase that passes raw samples until the lane
// has seen its length in scans. A scan enters the multiply step only once
// the previous scan has left the update step, since each lane's integral
// goes through the reciprocal multiplier into a product register, is written
// back on the update step, and the following scan must see the updated
// integral. A stalled result holds in the output register while the
// pipeline keeps filling behind it. Register writes are taken at any time
// (ready is always high) and must only be issued while no scan is in flight.
// ----------------------------------------------------------------------------
module battery_monitor_filter_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmf_in_if.sink           in_i,
  bmf_out_if.source        out_o,
  bmf_cfg_if.sink          cfg_i
);
  import bmf_pkg::*;

  localparam int NSTG = 6;

  cfg_t              cfg_q;
  logic [NSTG-1:0]   vld_q, vld_d;
  logic [NSTG-2:0]   en;
  logic              accept, pop;
  lane_ctl_t         lane_ctl;
  merge_ctl_t        merge_ctl;
  logic [BATT_W-1:0] batt_smp, curr_smp, temp_smp;
  logic [BATT_W-1:0] batt_filt, curr_filt, temp_filt;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_BATT_OFFSET: cfg_q.battery_offset <= cfg_i.data[SAMPLE_BITS-1:0];
        CFG_TEMP_GAIN:   cfg_q.temp_gain      <= cfg_i.data;
        CFG_TEMP_OFFSET: cfg_q.temp_offset    <= cfg_i.data;
        CFG_CHARGE_LOW:  cfg_q.charge_low     <= cfg_i.data[SAMPLE_BITS-1:0];
        CFG_CHARGE_HIGH: cfg_q.charge_high    <= cfg_i.data[SAMPLE_BITS-1:0];
        CFG_HOLD_COUNT:  cfg_q.hold_count     <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // stage k moves to k+1 on en[k]; stage 0 only moves into an empty stage 1
  // so its multiply always sees the integral left by the previous scan
  assign pop = vld_q[NSTG-1] & out_o.ready;
  always_comb begin
    en[0]      = vld_q[0] & ~vld_q[1];
    en[NSTG-2] = vld_q[NSTG-2] & (~vld_q[NSTG-1] | pop);
    for (int k = NSTG - 3; k >= 1; k--) begin
      en[k] = vld_q[k] & (~vld_q[k+1] | en[k+1]);
    end
  end

  assign in_i.ready = ~vld_q[0] | en[0];
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    vld_d[0] = accept | (vld_q[0] & ~en[0]);
    for (int k = 1; k < NSTG - 1; k++) begin
      vld_d[k] = en[k-1] | (vld_q[k] & ~en[k]);
    end
    vld_d[NSTG-1] = en[NSTG-2] | (vld_q[NSTG-1] & ~pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign lane_ctl.load = accept;
  assign lane_ctl.mul  = en[0];
  assign lane_ctl.upd  = en[1];
  assign lane_ctl.fin  = en[2];
  assign merge_ctl.cap = en[3];
  assign merge_ctl.out = en[4];

  assign batt_smp = BATT_W'(in_i.data.battery_sample) + BATT_W'(cfg_q.battery_offset);
  assign curr_smp = BATT_W'(in_i.data.current_sample);
  assign temp_smp = BATT_W'(in_i.data.temp_sample);

  bmf_lane u_lane_batt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lane_i (LANE_BATT),
    .ctl_i  (lane_ctl),
    .smp_i  (batt_smp),
    .filt_o (batt_filt)
  );

  bmf_lane u_lane_curr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lane_i (LANE_CURR),
    .ctl_i  (lane_ctl),
    .smp_i  (curr_smp),
    .filt_o (curr_filt)
  );

  bmf_lane u_lane_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lane_i (LANE_TEMP),
    .ctl_i  (lane_ctl),
    .smp_i  (temp_smp),
    .filt_o (temp_filt)
  );

  bmf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (merge_ctl),
    .cfg_i       (cfg_q),
    .batt_filt_i (batt_filt),
    .curr_filt_i (curr_filt),
    .temp_filt_i (temp_filt),
    .item_o      (out_o.data)
  );

  assign out_o.valid = vld_q[NSTG-1];

endmodule
